### src/jst_pkg.sv
// ----------------------------------------------------------------------------
// JSON tokenizer package
// Shared types, codes and character helpers of the JSON stream tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int FQ_DEPTH = 4;
	localparam int MAX_EV = 4;

	typedef logic [4:0] mode_t;

	localparam mode_t M_VALUE     = 5'd0;
	localparam mode_t M_ARR_FIRST = 5'd1;
	localparam mode_t M_OBJ_FIRST = 5'd2;
	localparam mode_t M_OBJ_KEY   = 5'd3;
	localparam mode_t M_COLON     = 5'd4;
	localparam mode_t M_AFTER     = 5'd5;
	localparam mode_t M_DONE      = 5'd6;
	localparam mode_t M_STR       = 5'd7;
	localparam mode_t M_ESC       = 5'd8;
	localparam mode_t M_HEX       = 5'd9;
	localparam mode_t M_SUR_BS    = 5'd10;
	localparam mode_t M_SUR_U     = 5'd11;
	localparam mode_t M_SUR_HEX   = 5'd12;
	localparam mode_t M_N_SIGN    = 5'd13;
	localparam mode_t M_N_ZERO    = 5'd14;
	localparam mode_t M_N_INT     = 5'd15;
	localparam mode_t M_N_DOT     = 5'd16;
	localparam mode_t M_N_FRAC    = 5'd17;
	localparam mode_t M_N_EXP     = 5'd18;
	localparam mode_t M_N_EXPS    = 5'd19;
	localparam mode_t M_N_EXPD    = 5'd20;
	localparam mode_t M_LIT_T     = 5'd21;
	localparam mode_t M_LIT_F     = 5'd22;
	localparam mode_t M_LIT_N     = 5'd23;

	localparam logic [3:0] EV_KEY_BYTE  = 4'd0;
	localparam logic [3:0] EV_KEY_END   = 4'd1;
	localparam logic [3:0] EV_STR_BYTE  = 4'd2;
	localparam logic [3:0] EV_STR_END   = 4'd3;
	localparam logic [3:0] EV_NUM_BYTE  = 4'd4;
	localparam logic [3:0] EV_NUM_END   = 4'd5;
	localparam logic [3:0] EV_TRUE      = 4'd6;
	localparam logic [3:0] EV_OBJ_OPEN  = 4'd9;
	localparam logic [3:0] EV_OBJ_CLOSE = 4'd10;
	localparam logic [3:0] EV_ARR_OPEN  = 4'd11;
	localparam logic [3:0] EV_ARR_CLOSE = 4'd12;
	localparam logic [3:0] EV_ACCEPTED  = 4'd13;
	localparam logic [3:0] EV_ERROR     = 4'd14;

	localparam logic [2:0] ER_NONE     = 3'd0;
	localparam logic [2:0] ER_UNEXP    = 3'd1;
	localparam logic [2:0] ER_DEEP     = 3'd2;
	localparam logic [2:0] ER_ESCAPE   = 3'd3;
	localparam logic [2:0] ER_SURR     = 3'd4;
	localparam logic [2:0] ER_CTRL     = 3'd5;
	localparam logic [2:0] ER_EARLY    = 3'd6;
	localparam logic [2:0] ER_TRAILING = 3'd7;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] data;
		logic [2:0] err;
		logic [6:0] lvl;
	} event_t;

	typedef struct packed {
		logic [2:0] n;
		event_t [MAX_EV-1:0] ev;
	} bundle_t;

	function automatic event_t mk_ev(logic [3:0] kind, logic [7:0] data, logic [2:0] err,
		logic [6:0] lvl);
		event_t e;
		e.kind = kind;
		e.data = data;
		e.err = err;
		e.lvl = lvl;
		return e;
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic logic [2:0] lit_len(logic [1:0] li);
		return (li == 2'd1) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] lit_char(logic [1:0] li, logic [2:0] k);
		logic [7:0] r;
		r = 8'h00;
		case ({li, k})
			5'b00_000: r = 8'h74;
			5'b00_001: r = 8'h72;
			5'b00_010: r = 8'h75;
			5'b00_011: r = 8'h65;
			5'b01_000: r = 8'h66;
			5'b01_001: r = 8'h61;
			5'b01_010: r = 8'h6C;
			5'b01_011: r = 8'h73;
			5'b01_100: r = 8'h65;
			5'b10_000: r = 8'h6E;
			5'b10_001: r = 8'h75;
			5'b10_010: r = 8'h6C;
			5'b10_011: r = 8'h6C;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### src/jst_front.sv
// ----------------------------------------------------------------------------
// JSON tokenizer front end
// Takes one byte per beat, runs the grammar and emits an event bundle.
// ----------------------------------------------------------------------------
module jst_front #(
	parameter int STACK_DEPTH = jst_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        in_byte,
	input  logic              end_of_text,
	input  logic [6:0]        max_depth,
	output logic              bnd_we,
	output jst_pkg::bundle_t  bnd
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [CW-1:0]   cnt_q;
	jst_pkg::mode_t  mode_q;
	logic [15:0]     hex_q;
	logic [9:0]      hs_q;
	logic [2:0]      sub_q;
	logic            err_q;
	logic            top_q;
	logic            below_q;
	logic            stk_mem [STACK_DEPTH];

	logic [CW-1:0]   cnt;
	jst_pkg::mode_t  m;
	logic [15:0]     hex;
	logic [9:0]      hs;
	logic [2:0]      sub;
	logic            err;
	logic            push_stk;
	logic            push_val;
	logic            pop_stk;
	logic [2:0]      n;
	jst_pkg::event_t [jst_pkg::MAX_EV-1:0] ev;
	logic [CW-1:0]   cnt_nxt;
	logic [AW-1:0]   rd_addr;

	always_comb begin
		logic [7:0]  c;
		logic        eot;
		logic        handled;
		logic        topv;
		logic [4:0]  hv;
		logic        hex_done;
		logic [20:0] cp;
		logic [3:0]  sk;
		logic [1:0]  li;
		int          lim;
		c = in_byte;
		eot = end_of_text || (c == 8'h00);
		handled = 1'b0;
		topv = 1'b0;
		hv = 5'd0;
		hex_done = 1'b0;
		cp = 21'd0;
		sk = jst_pkg::EV_STR_BYTE;
		li = 2'd0;
		lim = (int'(max_depth) < STACK_DEPTH) ? int'(max_depth) : STACK_DEPTH;
		cnt = cnt_q;
		m = mode_q;
		hex = hex_q;
		hs = hs_q;
		sub = sub_q;
		err = err_q;
		push_stk = 1'b0;
		push_val = 1'b0;
		pop_stk = 1'b0;
		n = 3'd0;
		ev = '0;
		if (eot) begin
			if (!err_q) begin
				if (m == jst_pkg::M_N_ZERO || m == jst_pkg::M_N_INT ||
					m == jst_pkg::M_N_FRAC || m == jst_pkg::M_N_EXPD) begin
					ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_NUM_END, 8'h00,
						jst_pkg::ER_NONE, 7'(cnt));
					n = n + 3'd1;
					m = (cnt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_DONE;
				end
				if (m == jst_pkg::M_DONE) begin
					ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ACCEPTED, 8'h00,
						jst_pkg::ER_NONE, 7'(cnt));
				end else begin
					ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
						jst_pkg::ER_EARLY, 7'(cnt));
				end
				n = n + 3'd1;
			end
			cnt = '0;
			m = jst_pkg::M_VALUE;
			hex = 16'd0;
			hs = 10'd0;
			sub = 3'd0;
			err = 1'b0;
		end else if (!err_q) begin
			sk = sub[2] ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE;
			if (m == jst_pkg::M_N_ZERO || m == jst_pkg::M_N_INT ||
				m == jst_pkg::M_N_FRAC || m == jst_pkg::M_N_EXPD) begin
				handled = 1'b1;
				if (jst_pkg::is_digit(c) && m != jst_pkg::M_N_ZERO) begin
					ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_NUM_BYTE, c,
						jst_pkg::ER_NONE, 7'(cnt));
					n = n + 3'd1;
				end else if (c == 8'h2E && (m == jst_pkg::M_N_ZERO ||
					m == jst_pkg::M_N_INT)) begin
					ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_NUM_BYTE, c,
						jst_pkg::ER_NONE, 7'(cnt));
					n = n + 3'd1;
					m = jst_pkg::M_N_DOT;
				end else if ((c == 8'h65 || c == 8'h45) && m != jst_pkg::M_N_EXPD) begin
					ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_NUM_BYTE, c,
						jst_pkg::ER_NONE, 7'(cnt));
					n = n + 3'd1;
					m = jst_pkg::M_N_EXP;
				end else begin
					ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_NUM_END, 8'h00,
						jst_pkg::ER_NONE, 7'(cnt));
					n = n + 3'd1;
					m = (cnt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_DONE;
					handled = 1'b0;
				end
			end
			topv = (cnt != '0) && top_q;
			if (!handled && !(m <= jst_pkg::M_DONE && jst_pkg::is_ws(c))) begin
				unique case (m)
					jst_pkg::M_VALUE, jst_pkg::M_ARR_FIRST: begin
						if (m == jst_pkg::M_ARR_FIRST && c == 8'h5D) begin
							cnt = cnt - 1'b1;
							pop_stk = 1'b1;
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ARR_CLOSE, 8'h00,
								jst_pkg::ER_NONE, 7'(cnt));
							n = n + 3'd1;
							m = (cnt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_DONE;
						end else if (int'(cnt) + 1 > lim) begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_DEEP, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end else begin
							sub = 3'd0;
							if (c == 8'h22) begin
								m = jst_pkg::M_STR;
							end else if (c == 8'h7B || c == 8'h5B) begin
								push_stk = 1'b1;
								push_val = (c == 8'h7B);
								cnt = cnt + 1'b1;
								ev[n[1:0]] = jst_pkg::mk_ev(push_val ? jst_pkg::EV_OBJ_OPEN :
									jst_pkg::EV_ARR_OPEN, 8'h00, jst_pkg::ER_NONE, 7'(cnt));
								n = n + 3'd1;
								m = push_val ? jst_pkg::M_OBJ_FIRST : jst_pkg::M_ARR_FIRST;
							end else if (c == 8'h74) begin
								m = jst_pkg::M_LIT_T;
								sub = 3'd1;
							end else if (c == 8'h66) begin
								m = jst_pkg::M_LIT_F;
								sub = 3'd1;
							end else if (c == 8'h6E) begin
								m = jst_pkg::M_LIT_N;
								sub = 3'd1;
							end else if (c == 8'h2D || jst_pkg::is_digit(c)) begin
								ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_NUM_BYTE, c,
									jst_pkg::ER_NONE, 7'(cnt));
								n = n + 3'd1;
								m = (c == 8'h2D) ? jst_pkg::M_N_SIGN :
									(c == 8'h30) ? jst_pkg::M_N_ZERO : jst_pkg::M_N_INT;
							end else begin
								ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
									jst_pkg::ER_UNEXP, 7'(cnt));
								n = n + 3'd1;
								err = 1'b1;
							end
						end
					end
					jst_pkg::M_OBJ_FIRST, jst_pkg::M_OBJ_KEY: begin
						if (m == jst_pkg::M_OBJ_FIRST && c == 8'h7D) begin
							cnt = cnt - 1'b1;
							pop_stk = 1'b1;
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_OBJ_CLOSE, 8'h00,
								jst_pkg::ER_NONE, 7'(cnt));
							n = n + 3'd1;
							m = (cnt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_DONE;
						end else if (c == 8'h22) begin
							m = jst_pkg::M_STR;
							sub = 3'd4;
						end else begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_UNEXP, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end
					end
					jst_pkg::M_COLON: begin
						if (c == 8'h3A) begin
							m = jst_pkg::M_VALUE;
						end else begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_UNEXP, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end
					end
					jst_pkg::M_AFTER: begin
						if (c == 8'h2C) begin
							m = topv ? jst_pkg::M_OBJ_KEY : jst_pkg::M_VALUE;
						end else if ((c == 8'h7D && topv) || (c == 8'h5D && !topv)) begin
							cnt = cnt - 1'b1;
							pop_stk = 1'b1;
							ev[n[1:0]] = jst_pkg::mk_ev(topv ? jst_pkg::EV_OBJ_CLOSE :
								jst_pkg::EV_ARR_CLOSE, 8'h00, jst_pkg::ER_NONE, 7'(cnt));
							n = n + 3'd1;
							m = (cnt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_DONE;
						end else begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_UNEXP, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end
					end
					jst_pkg::M_DONE: begin
						ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
							jst_pkg::ER_TRAILING, 7'(cnt));
						n = n + 3'd1;
						err = 1'b1;
					end
					jst_pkg::M_STR: begin
						if (c == 8'h22) begin
							ev[n[1:0]] = jst_pkg::mk_ev(sub[2] ? jst_pkg::EV_KEY_END :
								jst_pkg::EV_STR_END, 8'h00, jst_pkg::ER_NONE, 7'(cnt));
							n = n + 3'd1;
							if (sub[2]) begin
								m = jst_pkg::M_COLON;
							end else begin
								m = (cnt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_DONE;
							end
							sub = 3'd0;
						end else if (c == 8'h5C) begin
							m = jst_pkg::M_ESC;
						end else if (c < 8'h20) begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_CTRL, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end else begin
							ev[n[1:0]] = jst_pkg::mk_ev(sk, c, jst_pkg::ER_NONE, 7'(cnt));
							n = n + 3'd1;
						end
					end
					jst_pkg::M_ESC: begin
						m = jst_pkg::M_STR;
						case (c)
							8'h22, 8'h5C, 8'h2F: begin
								ev[n[1:0]] = jst_pkg::mk_ev(sk, c, jst_pkg::ER_NONE, 7'(cnt));
								n = n + 3'd1;
							end
							8'h62, 8'h66, 8'h6E, 8'h72, 8'h74: begin
								ev[n[1:0]] = jst_pkg::mk_ev(sk, (c == 8'h62) ? 8'd8 :
									(c == 8'h66) ? 8'd12 : (c == 8'h6E) ? 8'd10 :
									(c == 8'h72) ? 8'd13 : 8'd9, jst_pkg::ER_NONE, 7'(cnt));
								n = n + 3'd1;
							end
							8'h75: begin
								m = jst_pkg::M_HEX;
								hex = 16'd0;
								sub = {sub[2], 2'b00};
							end
							default: begin
								ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
									jst_pkg::ER_ESCAPE, 7'(cnt));
								n = n + 3'd1;
								err = 1'b1;
							end
						endcase
					end
					jst_pkg::M_HEX, jst_pkg::M_SUR_HEX: begin
						hv = jst_pkg::hex_val(c);
						if (!hv[4]) begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_ESCAPE, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end else begin
							hex = {hex[11:0], hv[3:0]};
							if (sub[1:0] != 2'd3) begin
								sub[1:0] = sub[1:0] + 2'd1;
							end else begin
								sub[1:0] = 2'd0;
								hex_done = 1'b1;
							end
						end
						if (hex_done) begin
							if (m == jst_pkg::M_HEX && hex >= 16'hD800 && hex <= 16'hDBFF) begin
								hs = hex[9:0];
								m = jst_pkg::M_SUR_BS;
							end else if ((m == jst_pkg::M_HEX) == (hex >= 16'hDC00 &&
								hex <= 16'hDFFF)) begin
								ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
									jst_pkg::ER_SURR, 7'(cnt));
								n = n + 3'd1;
								err = 1'b1;
							end else begin
								if (m == jst_pkg::M_HEX) begin
									cp = {5'd0, hex};
								end else begin
									cp = 21'h10000 + {1'b0, hs, hex[9:0]};
								end
								m = jst_pkg::M_STR;
								if (cp < 21'h80) begin
									ev[0] = jst_pkg::mk_ev(sk, cp[7:0], jst_pkg::ER_NONE,
										7'(cnt));
									n = 3'd1;
								end else if (cp < 21'h800) begin
									ev[0] = jst_pkg::mk_ev(sk, {3'b110, cp[10:6]},
										jst_pkg::ER_NONE, 7'(cnt));
									ev[1] = jst_pkg::mk_ev(sk, {2'b10, cp[5:0]},
										jst_pkg::ER_NONE, 7'(cnt));
									n = 3'd2;
								end else if (cp < 21'h10000) begin
									ev[0] = jst_pkg::mk_ev(sk, {4'b1110, cp[15:12]},
										jst_pkg::ER_NONE, 7'(cnt));
									ev[1] = jst_pkg::mk_ev(sk, {2'b10, cp[11:6]},
										jst_pkg::ER_NONE, 7'(cnt));
									ev[2] = jst_pkg::mk_ev(sk, {2'b10, cp[5:0]},
										jst_pkg::ER_NONE, 7'(cnt));
									n = 3'd3;
								end else begin
									ev[0] = jst_pkg::mk_ev(sk, {5'b11110, cp[20:18]},
										jst_pkg::ER_NONE, 7'(cnt));
									ev[1] = jst_pkg::mk_ev(sk, {2'b10, cp[17:12]},
										jst_pkg::ER_NONE, 7'(cnt));
									ev[2] = jst_pkg::mk_ev(sk, {2'b10, cp[11:6]},
										jst_pkg::ER_NONE, 7'(cnt));
									ev[3] = jst_pkg::mk_ev(sk, {2'b10, cp[5:0]},
										jst_pkg::ER_NONE, 7'(cnt));
									n = 3'd4;
								end
							end
						end
					end
					jst_pkg::M_SUR_BS, jst_pkg::M_SUR_U: begin
						if (m == jst_pkg::M_SUR_BS && c == 8'h5C) begin
							m = jst_pkg::M_SUR_U;
						end else if (m == jst_pkg::M_SUR_U && c == 8'h75) begin
							m = jst_pkg::M_SUR_HEX;
							hex = 16'd0;
							sub = {sub[2], 2'b00};
						end else begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_SURR, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end
					end
					jst_pkg::M_N_SIGN, jst_pkg::M_N_DOT, jst_pkg::M_N_EXPS,
					jst_pkg::M_N_EXP: begin
						if (jst_pkg::is_digit(c) || (m == jst_pkg::M_N_EXP &&
							(c == 8'h2B || c == 8'h2D))) begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_NUM_BYTE, c,
								jst_pkg::ER_NONE, 7'(cnt));
							n = n + 3'd1;
							if (m == jst_pkg::M_N_SIGN) begin
								m = (c == 8'h30) ? jst_pkg::M_N_ZERO : jst_pkg::M_N_INT;
							end else if (m == jst_pkg::M_N_DOT) begin
								m = jst_pkg::M_N_FRAC;
							end else if (m == jst_pkg::M_N_EXP && !jst_pkg::is_digit(c)) begin
								m = jst_pkg::M_N_EXPS;
							end else begin
								m = jst_pkg::M_N_EXPD;
							end
						end else begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_UNEXP, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end
					end
					jst_pkg::M_LIT_T, jst_pkg::M_LIT_F, jst_pkg::M_LIT_N: begin
						li = 2'(m - jst_pkg::M_LIT_T);
						if (sub >= jst_pkg::lit_len(li) || c != jst_pkg::lit_char(li, sub)) begin
							ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
								jst_pkg::ER_UNEXP, 7'(cnt));
							n = n + 3'd1;
							err = 1'b1;
						end else begin
							sub = sub + 3'd1;
							if (sub == jst_pkg::lit_len(li)) begin
								sub = 3'd0;
								ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_TRUE + 4'(li), 8'h00,
									jst_pkg::ER_NONE, 7'(cnt));
								n = n + 3'd1;
								m = (cnt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_DONE;
							end
						end
					end
					default: begin
						ev[n[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'h00,
							jst_pkg::ER_UNEXP, 7'(cnt));
						n = n + 3'd1;
						err = 1'b1;
					end
				endcase
			end
		end
	end

	assign cnt_nxt = acc ? cnt : cnt_q;
	assign rd_addr = AW'(cnt_nxt - CW'(2));
	assign bnd_we = acc && (n != 3'd0);
	assign bnd.n = n;
	assign bnd.ev = ev;

	always_ff @(posedge clk) begin
		if (acc && push_stk) begin
			stk_mem[cnt_q[AW-1:0]] <= push_val;
		end
		below_q <= stk_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mode_q <= jst_pkg::M_VALUE;
			hex_q <= 16'd0;
			hs_q <= 10'd0;
			sub_q <= 3'd0;
			err_q <= 1'b0;
			top_q <= 1'b0;
		end else if (acc) begin
			cnt_q <= cnt;
			mode_q <= m;
			hex_q <= hex;
			hs_q <= hs;
			sub_q <= sub;
			err_q <= err;
			if (push_stk) begin
				top_q <= push_val;
			end else if (pop_stk) begin
				top_q <= below_q;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= STACK_DEPTH) else $error("open count beyond stack depth");
	a_ev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n <= 3'(jst_pkg::MAX_EV)) else $error("too many events in one beat");
	a_eot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (end_of_text || in_byte == 8'h00) |=> cnt_q == '0 &&
		mode_q == jst_pkg::M_VALUE && !err_q) else $error("end of text did not restart");

endmodule

### src/jst_back.sv
// ----------------------------------------------------------------------------
// JSON tokenizer back end
// Queues event bundles and hands out their events one beat at a time.
// ----------------------------------------------------------------------------
module jst_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              bnd_we,
	input  jst_pkg::bundle_t  bnd,
	output logic              bfull,
	input  logic              pop,
	output logic              empty,
	output logic [3:0]        event_kind,
	output logic [7:0]        data_byte,
	output logic [2:0]        error_code,
	output logic [6:0]        nesting_level,
	output logic              last_of_run
);

	localparam int FA = $clog2(jst_pkg::FQ_DEPTH);

	jst_pkg::bundle_t fq_q [jst_pkg::FQ_DEPTH];
	logic [FA-1:0]    wp_q;
	logic [FA-1:0]    rp_q;
	logic [FA:0]      fc_q;
	jst_pkg::bundle_t cur_q;
	logic             cur_v_q;
	logic [1:0]       idx_q;
	logic             last;
	logic             ld;
	jst_pkg::event_t  e;

	assign bfull = (fc_q == (FA+1)'(jst_pkg::FQ_DEPTH));
	assign last = ((3'(idx_q) + 3'd1) == cur_q.n);
	assign ld = (fc_q != '0) && (!cur_v_q || (pop && last));
	assign e = cur_q.ev[idx_q];
	assign empty = !cur_v_q;
	assign event_kind = e.kind;
	assign data_byte = e.data;
	assign error_code = e.err;
	assign nesting_level = e.lvl;
	assign last_of_run = last;

	always_ff @(posedge clk) begin
		if (bnd_we) begin
			fq_q[wp_q] <= bnd;
		end
		if (ld) begin
			cur_q <= fq_q[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fc_q <= '0;
			cur_v_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (bnd_we) begin
				wp_q <= wp_q + 1'b1;
			end
			if (ld) begin
				rp_q <= rp_q + 1'b1;
			end
			fc_q <= fc_q + (FA+1)'(bnd_we) - (FA+1)'(ld);
			if (ld) begin
				cur_v_q <= 1'b1;
				idx_q <= 2'd0;
			end else if (pop && cur_v_q) begin
				if (last) begin
					cur_v_q <= 1'b0;
				end
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_we |-> !bfull || ld) else $error("bundle queue overflow");
	a_cur_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> cur_q.n != 3'd0) else $error("empty bundle in output stage");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= (FA+1)'(jst_pkg::FQ_DEPTH)) else $error("bundle queue count out of range");

endmodule

### src/json_stream_tokenizer_top.sv
// ----------------------------------------------------------------------------
// JSON stream tokenizer
// Validates JSON text byte by byte and emits token events.
// ----------------------------------------------------------------------------
// Input: one text byte (or end_of_text) per beat, taken when push is high and
// full is low. A zero byte counts as end of text. One beat is taken every
// cycle while full stays low.
// Output: events leave through a queue-style port; the oldest event sits on
// the result ports while empty is low and is taken when pop is high. A byte
// gives zero to four events; last_of_run marks the final one of a byte.
// A byte's bundle is registered in the queue, then in the output stage. Each
// event takes one output cycle while pop stays high, so a multi-byte UTF-8
// sequence from one byte gives up to four events in a row on the output port.
// A four-entry bundle queue between the parser and the output stage absorbs
// such bursts; when pop stays low the queue fills and full rises.
// The container kind stack is a memory of STACK_DEPTH one-bit entries.
// Reset clears all parse state and sets max_depth to 64; the user must write
// max_depth via cfg_wr_en and cfg_wr_data only while idle; not enforced here.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_top #(
	parameter int STACK_DEPTH = jst_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] event_kind,
	output logic [7:0] data_byte,
	output logic [2:0] error_code,
	output logic [6:0] nesting_level,
	output logic       last_of_run
);

	logic             acc;
	logic             bnd_we;
	jst_pkg::bundle_t bnd;
	logic [6:0]       max_depth_q;

	assign acc = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= 7'd64;
		end else if (cfg_wr_en) begin
			max_depth_q <= cfg_wr_data;
		end
	end

	jst_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.max_depth   (max_depth_q),
		.bnd_we      (bnd_we),
		.bnd         (bnd)
	);

	jst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.bnd_we        (bnd_we),
		.bnd           (bnd),
		.bfull         (full),
		.pop           (pop),
		.empty         (empty),
		.event_kind    (event_kind),
		.data_byte     (data_byte),
		.error_code    (error_code),
		.nesting_level (nesting_level),
		.last_of_run   (last_of_run)
	);

endmodule
